// ===== src/imu_ca_pkg.sv =====
// Package with shared constants and the CORDIC arctangent table for the attitude filter.
`default_nettype none
package imu_ca_pkg;

	localparam int DataW = 32;
	localparam int CordW = 50;
	localparam int AngW = 34;

	localparam logic [15:0] WKeepSlow = 16'd65208;
	localparam logic [15:0] WNewSlow = 16'd328;
	localparam logic [15:0] WKeepFast = 16'd58982;
	localparam logic [15:0] WNewFast = 16'd6554;
	localparam logic [31:0] InvGain = 32'd2608131496;
	localparam logic signed [AngW-1:0] Deg90 = 34'sd1509949440;

	function automatic logic signed [AngW-1:0] atan_deg24(input logic [4:0] idx);
		logic signed [AngW-1:0] r;
		begin
			case (idx)
				5'd0: r = 34'sd754974720;
				5'd1: r = 34'sd445687602;
				5'd2: r = 34'sd235489088;
				5'd3: r = 34'sd119537938;
				5'd4: r = 34'sd60000934;
				5'd5: r = 34'sd30029717;
				5'd6: r = 34'sd15018523;
				5'd7: r = 34'sd7509720;
				5'd8: r = 34'sd3754917;
				5'd9: r = 34'sd1877466;
				5'd10: r = 34'sd938734;
				5'd11: r = 34'sd469367;
				5'd12: r = 34'sd234684;
				5'd13: r = 34'sd117342;
				5'd14: r = 34'sd58671;
				5'd15: r = 34'sd29335;
				5'd16: r = 34'sd14668;
				5'd17: r = 34'sd7334;
				5'd18: r = 34'sd3667;
				5'd19: r = 34'sd1833;
				5'd20: r = 34'sd917;
				5'd21: r = 34'sd458;
				5'd22: r = 34'sd229;
				5'd23: r = 34'sd115;
				5'd24: r = 34'sd57;
				5'd25: r = 34'sd29;
				5'd26: r = 34'sd14;
				5'd27: r = 34'sd7;
				5'd28: r = 34'sd4;
				5'd29: r = 34'sd2;
				5'd30: r = 34'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/imu_complementary_attitude.sv =====
// Complementary pitch and roll filter with a shared iterative CORDIC and serial multiplier.
// The first sample after reset skips integration and the slow blend. A new sample is accepted
// only in the idle state, so the block finishes the previous result before it takes the next.
// Each sample passes through the CORDIC (one iteration a cycle) for roll and then pitch, the
// serial gain step and up to ten serial products.
// Reset clears the state, sample_period returns to 655, and the output is empty.
`default_nettype none
module imu_complementary_attitude #(
	parameter int CORDIC_STEPS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_wdata,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// gyro_rate_x, gyro_rate_y, gyro_rate_z, accel_x, accel_y, accel_z
	input wire logic [191:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// pitch_angle, roll_angle, yaw_rate
	output logic [95:0] m_axis_tdata
);

	localparam int Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int CW = imu_ca_pkg::CordW;
	localparam int AW = imu_ca_pkg::AngW;

	localparam logic [3:0] StIdle = 4'd0;
	localparam logic [3:0] StRollPre = 4'd1;
	localparam logic [3:0] StRollRun = 4'd2;
	localparam logic [3:0] StGain = 4'd3;
	localparam logic [3:0] StPitchPre = 4'd4;
	localparam logic [3:0] StPitchRun = 4'd5;
	localparam logic [3:0] StMul = 4'd6;
	localparam logic [3:0] StOut = 4'd7;

	logic [3:0] state_q;
	logic [15:0] period_q;
	logic started_q;
	logic signed [31:0] gp_acc_q, gr_acc_q, sp_q, sr_q;
	logic signed [31:0] gx_q, gy_q, gz_q, ax_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [AW-1:0] cz_q;
	logic [5:0] it_q;
	logic signed [31:0] aroll_q, apitch_q;
	logic [4:0] op_q;
	logic [5:0] bit_q;
	logic signed [63:0] acc_q;
	logic [63:0] gacc_q;
	logic signed [31:0] p_q, r_q;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		begin
			if (v > 66'sd2147483647) return 32'sh7fffffff;
			else if (v < -66'sd2147483648) return 32'sh80000000;
			else return v[31:0];
		end
	endfunction

	function automatic logic signed [31:0] rnd16(input logic signed [63:0] v);
		logic signed [65:0] t;
		begin
			t = ($signed({{2{v[63]}}, v}) + 66'sd32768) >>> 16;
			return sat32(t);
		end
	endfunction

	// Multiplier operand selection: signed 32-bit a times unsigned 16-bit b.
	logic signed [31:0] m_a;
	logic [15:0] m_b;
	always_comb begin
		m_a = '0;
		m_b = '0;
		case (op_q)
			5'd0: begin m_a = gy_q; m_b = period_q; end
			5'd1: begin m_a = gx_q; m_b = period_q; end
			5'd2: begin m_a = p_q; m_b = imu_ca_pkg::WKeepSlow; end
			5'd3: begin m_a = apitch_q; m_b = imu_ca_pkg::WNewSlow; end
			5'd4: begin m_a = r_q; m_b = imu_ca_pkg::WKeepSlow; end
			5'd5: begin m_a = aroll_q; m_b = imu_ca_pkg::WNewSlow; end
			5'd6: begin m_a = sp_q; m_b = imu_ca_pkg::WKeepFast; end
			5'd7: begin m_a = gp_acc_q; m_b = imu_ca_pkg::WNewFast; end
			5'd8: begin m_a = sr_q; m_b = imu_ca_pkg::WKeepFast; end
			5'd9: begin m_a = gr_acc_q; m_b = imu_ca_pkg::WNewFast; end
			default: ;
		endcase
	end

	logic signed [CW-1:0] xs, ys;
	logic signed [CW-1:0] pre_x, pre_y;
	logic signed [AW-1:0] pre_z;
	logic zero_vec;
	logic signed [AW+1:0] ang_r;
	logic signed [31:0] ang_q16;
	assign xs = cx_q >>> it_q[4:0];
	assign ys = cy_q >>> it_q[4:0];
	assign zero_vec = (cx_q == '0) && (cy_q == '0);
	assign ang_r = ($signed({{2{cz_q[AW-1]}}, cz_q}) + 36'sd128) >>> 8;
	assign ang_q16 = sat32({{30{ang_r[AW+1]}}, ang_r});

	always_comb begin
		pre_x = cx_q;
		pre_y = cy_q;
		pre_z = '0;
		if (cx_q < 0) begin
			if (cy_q >= 0) begin
				pre_x = cy_q; pre_y = -cx_q; pre_z = imu_ca_pkg::Deg90;
			end else begin
				pre_x = -cy_q; pre_y = cx_q; pre_z = -imu_ca_pkg::Deg90;
			end
		end
	end

	// Gain removal: hi*InvGain + (lo*InvGain >> 16), computed one bit of hi per cycle.
	logic [CW-2:0] umag_q;
	logic [47:0] lo_prod;
	assign lo_prod = 48'(umag_q[15:0]) * 48'(imu_ca_pkg::InvGain);

	logic signed [47:0] pp;
	assign pp = $signed({{16{m_a[31]}}, m_a}) <<< bit_q[3:0];

	assign s_axis_tready = (state_q == StIdle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			period_q <= 16'd655;
			started_q <= 1'b0;
			gp_acc_q <= '0;
			gr_acc_q <= '0;
			sp_q <= '0;
			sr_q <= '0;
			m_axis_tvalid <= 1'b0;
			it_q <= '0;
			op_q <= '0;
			bit_q <= '0;
		end else begin
			if (cfg_we) period_q <= cfg_wdata;
			if (m_axis_tvalid && m_axis_tready && state_q != StOut) m_axis_tvalid <= 1'b0;
			case (state_q)
				StIdle: begin
					if (s_axis_tvalid) begin
						gx_q <= s_axis_tdata[31:0];
						gy_q <= s_axis_tdata[63:32];
						gz_q <= s_axis_tdata[95:64];
						ax_q <= s_axis_tdata[127:96];
						cx_q <= CW'($signed(s_axis_tdata[191:160])) <<< 14;
						cy_q <= CW'($signed(s_axis_tdata[159:128])) <<< 14;
						state_q <= StRollPre;
					end
				end
				StRollPre, StPitchPre: begin
					cx_q <= pre_x;
					cy_q <= pre_y;
					cz_q <= pre_z;
					it_q <= zero_vec ? 6'(Steps) : 6'd0;
					state_q <= (state_q == StRollPre) ? StRollRun : StPitchRun;
				end
				StRollRun, StPitchRun: begin
					if (it_q < 6'(Steps)) begin
						if (cy_q >= 0) begin
							cx_q <= cx_q + ys;
							cy_q <= cy_q - xs;
							cz_q <= cz_q + imu_ca_pkg::atan_deg24(it_q[4:0]);
						end else begin
							cx_q <= cx_q - ys;
							cy_q <= cy_q + xs;
							cz_q <= cz_q - imu_ca_pkg::atan_deg24(it_q[4:0]);
						end
						it_q <= it_q + 6'd1;
					end else if (state_q == StRollRun) begin
						aroll_q <= ang_q16;
						umag_q <= (cx_q > 0) ? cx_q[CW-2:0] : '0;
						gacc_q <= '0;
						bit_q <= '0;
						state_q <= StGain;
					end else begin
						apitch_q <= sat32(-{{34{ang_q16[31]}}, ang_q16});
						op_q <= started_q ? 5'd0 : 5'd6;
						if (!started_q) begin
							gp_acc_q <= sat32(-{{34{ang_q16[31]}}, ang_q16});
							gr_acc_q <= aroll_q;
							started_q <= 1'b1;
						end
						bit_q <= '0;
						acc_q <= '0;
						state_q <= StMul;
					end
				end
				StGain: begin
					if (bit_q < 6'd33) begin
						if (umag_q[6'd16 + bit_q])
							gacc_q <= gacc_q + (64'(imu_ca_pkg::InvGain) << bit_q);
						bit_q <= bit_q + 6'd1;
					end else begin
						cx_q <= CW'((gacc_q + 64'(lo_prod[47:16])) >> 16);
						cy_q <= CW'($signed(ax_q)) <<< 14;
						state_q <= StPitchPre;
					end
				end
				StMul: begin
					if (bit_q < 6'd16) begin
						if (m_b[bit_q[3:0]])
							acc_q <= acc_q + 64'(pp);
						bit_q <= bit_q + 6'd1;
					end else begin
						bit_q <= '0;
						case (op_q)
							5'd0: begin
								p_q <= rnd16(acc_q + ($signed(64'(gp_acc_q)) <<< 16));
								acc_q <= '0;
							end
							5'd1: begin
								r_q <= rnd16(acc_q + ($signed(64'(gr_acc_q)) <<< 16));
								acc_q <= '0;
							end
							5'd3: begin gp_acc_q <= rnd16(acc_q); acc_q <= '0; end
							5'd5: begin gr_acc_q <= rnd16(acc_q); acc_q <= '0; end
							5'd7: begin sp_q <= rnd16(acc_q); acc_q <= '0; end
							5'd9: begin sr_q <= rnd16(acc_q); acc_q <= '0; end
							default: ;
						endcase
						if (op_q == 5'd9) state_q <= StOut;
						else op_q <= op_q + 5'd1;
					end
				end
				StOut: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StOut && (!m_axis_tvalid || m_axis_tready))
			m_axis_tdata <= {gz_q, sr_q, sp_q};
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (state_q == StIdle)) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
	a_it_bound: assert property (@(posedge clk) disable iff (!arst_n)
		it_q <= 6'(Steps)) else $error("cordic count overrun");

endmodule
`default_nettype wire

// ===== dv/imu_complementary_attitude_check.sv =====
// Checker that predicts the attitude filter results and compares them with the block output.
`default_nettype none
module imu_complementary_attitude_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_wdata,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [191:0] s_axis_tdata,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [95:0] m_axis_tdata,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Steps = 24;

	logic [15:0] period;
	longint pitch_acc, roll_acc, pitch_out, roll_out;
	bit started;
	logic [95:0] expected_q[$];

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_q16(longint v);
		return sat32((v + 32768) >>> 16);
	endfunction

	function automatic void vector_angle(longint xi, longint yi, output longint ang,
			output longint mag);
		longint x, y, z, t, xs, ys;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			ang = 0;
			mag = 0;
			return;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = longint'(imu_ca_pkg::Deg90);
			end else begin
				x = -y;
				y = t;
				z = -longint'(imu_ca_pkg::Deg90);
			end
		end
		for (int i = 0; i < Steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += longint'(imu_ca_pkg::atan_deg24(i[4:0]));
			end else begin
				x -= ys;
				y += xs;
				z -= longint'(imu_ca_pkg::atan_deg24(i[4:0]));
			end
		end
		ang = z;
		mag = x;
	endfunction

	function automatic longint scale_magnitude(longint x);
		longint unsigned u, hi, lo, g;
		u = (x > 0) ? x : 0;
		g = imu_ca_pkg::InvGain;
		hi = u >> 16;
		lo = u & 64'hFFFF;
		return longint'((hi * g + ((lo * g) >> 16)) >> 16);
	endfunction

	function automatic logic [95:0] predict_attitude(logic [191:0] d);
		longint gx, gy, gz, ax, ay, az, rang, rmag, pang, pmag, aroll, apitch, p, r;
		gx = longint'($signed(d[31:0]));
		gy = longint'($signed(d[63:32]));
		gz = longint'($signed(d[95:64]));
		ax = longint'($signed(d[127:96])) * 16384;
		ay = longint'($signed(d[159:128])) * 16384;
		az = longint'($signed(d[191:160])) * 16384;
		vector_angle(az, ay, rang, rmag);
		vector_angle(scale_magnitude(rmag), ax, pang, pmag);
		aroll = sat32((rang + 128) >>> 8);
		apitch = sat32(-sat32((pang + 128) >>> 8));
		if (started) begin
			p = round_q16(pitch_acc * 65536 + gy * longint'(period));
			r = round_q16(roll_acc * 65536 + gx * longint'(period));
			pitch_acc = round_q16(p * longint'(imu_ca_pkg::WKeepSlow)
				+ apitch * longint'(imu_ca_pkg::WNewSlow));
			roll_acc = round_q16(r * longint'(imu_ca_pkg::WKeepSlow)
				+ aroll * longint'(imu_ca_pkg::WNewSlow));
		end else begin
			pitch_acc = apitch;
			roll_acc = aroll;
			started = 1;
		end
		pitch_out = round_q16(pitch_out * longint'(imu_ca_pkg::WKeepFast)
			+ pitch_acc * longint'(imu_ca_pkg::WNewFast));
		roll_out = round_q16(roll_out * longint'(imu_ca_pkg::WKeepFast)
			+ roll_acc * longint'(imu_ca_pkg::WNewFast));
		return {gz[31:0], roll_out[31:0], pitch_out[31:0]};
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [95:0] want;
		if (!arst_n) begin
			period <= 16'd655;
			pitch_acc = 0;
			roll_acc = 0;
			pitch_out = 0;
			roll_out = 0;
			started = 0;
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("Unexpected result transaction %h", m_axis_tdata);
				end else begin
					want = expected_q.pop_front();
					if (want !== m_axis_tdata) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("Mismatch: pitch exp %h got %h, roll exp %h got %h, yaw exp %h got %h",
								want[31:0], m_axis_tdata[31:0], want[63:32], m_axis_tdata[63:32],
								want[95:64], m_axis_tdata[95:64]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(predict_attitude(s_axis_tdata));
			if (cfg_we)
				period <= cfg_wdata;
		end
	end
endmodule
`default_nettype wire

// ===== dv/imu_complementary_attitude_test.sv =====
// Testbench top that drives the attitude filter and reports the verdict.
`default_nettype none
module imu_complementary_attitude_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [95:0] m_axis_tdata;
	int fail_count, pending;
	bit long_hold = 0;

	always #5 clk = ~clk;

	imu_complementary_attitude DUT (.*);
	imu_complementary_attitude_check checker_inst (.*);

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
			4: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(logic [191:0] d);
		s_axis_tdata <= d;
		s_axis_tvalid <= 1;
		while (!s_axis_tready) @(negedge clk);
		@(negedge clk);
		s_axis_tvalid <= 0;
		@(negedge clk);
	endtask

	task automatic send_random(int n);
		logic [191:0] d;
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && n > 0) begin
				for (int f = 0; f < 6; f++)
					d[f*32 +: 32] = pick_value();
				send_sample(d);
				burst--;
				n--;
			end
			if ($urandom_range(0, 2) != 0)
				repeat ($urandom_range(1, 40)) @(negedge clk);
		end
	endtask

	task automatic write_period(logic [15:0] v);
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	always @(negedge clk) begin
		if (long_hold)
			m_axis_tready <= 0;
		else
			m_axis_tready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_sample('0);
		send_sample({6{32'h7FFFFFFF}});
		send_sample({6{32'h80000000}});
		send_sample({32'hFFFF0000, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0});
		send_sample({32'h0, 32'h0, 32'hFFFF0000, 32'h0, 32'h0, 32'h0});
		send_sample({32'h0, 32'hFFFF0000, 32'h0, 32'h0, 32'h0, 32'h0});
		send_sample({32'hFFFF0000, 32'hFFFF0000, 32'h00010000, 32'h1234, 32'h80000000,
			32'h7FFFFFFF});
		write_period(16'd0);
		send_random(10);
		write_period(16'hFFFF);
		send_random(10);
		write_period(16'd1);
		send_random(200);
		long_hold = 1;
		fork
			begin
				repeat (3000) @(negedge clk);
				long_hold = 0;
			end
			send_random(20);
		join
		write_period(16'd655);
		send_random(500);
		write_period(16'($urandom_range(1, 65535)));
		send_random(500);
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
